@@ hw/rtl/crg_pkg.sv @@
// Shared types and constants of the camera ray generator.
// Used by every module of the block; no dependencies of its own.
`default_nettype none
package crg_pkg;

    // Number of entries in the queue between front and back.
    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 3;

    // Square root of a 62-bit sum: one result bit per stage.
    localparam int SQRT_STEPS = 31;
    // Reciprocal 2^62 / L for L in [2^29, 2^31): quotient bits 33 down to 0.
    localparam int RECIP_STEPS = 34;
    // Target position of the leading one after normalization.
    localparam int NORM_POS = 29;
    // Split point of the reciprocal for the final two partial products.
    localparam int RSPLIT = 17;

    // Direction limits in Q2.30.
    localparam logic signed [35:0] DIR_MAX = 36'sd1073741824;
    localparam logic signed [35:0] DIR_MIN = -36'sd1073741824;

    // Register indexes of the configuration port.
    localparam logic [2:0] REG_PIXEL_SIZE = 3'd7;

    // Upper 3x3 part of the inverse view matrix, [row][column].
    typedef logic [2:0][2:0][31:0] t_mat3;

    // Image plane point handed from front to back.
    typedef struct packed {
        logic [31:0] px;
        logic [31:0] py;
        logic        deg;
    } t_plane;

    // Normalized components and flags riding along the root and divide stages.
    typedef struct packed {
        logic [2:0][31:0] c;
        logic             deg;
        logic             zero;
    } t_side;

endpackage
`default_nettype wire

@@ hw/rtl/camera_ray_generator_unit.sv @@
// Top level of the camera ray generator: configuration registers, front,
// queue and back parts. Depends on crg_pkg, crg_front, crg_queue, crg_back.
//
// Usage: pixel beats (column, row) enter on the i_in_valid / o_in_ready
// channel; one ray beat per pixel leaves on o_out_valid / i_out_ready, in
// order. The ray origin is the translation column of the matrix; the
// direction is a unit vector in Q2.30 and o_degenerate marks a saturated
// plane point or a zero-length direction.
// Throughput is one pixel per cycle while the receiver does not stall. A beat
// accepted at the input passes the front register, the queue and the back's
// 74 stages, of which 31 are the bit-per-stage square root and 34 the
// bit-per-stage reciprocal, before o_out_valid rises.
// When the receiver stalls, the whole back pipeline holds; the queue then
// fills and the front drops o_in_ready after a few more beats.
// Reset (synchronous, active low) empties all stages and loads the identity
// matrix, zero half extents and zero pixel size. The user must write the
// registers over APB only while no beat is in flight; the block does not check.
`default_nettype none
module camera_ray_generator_unit
    import crg_pkg::*;
#(
    parameter int PIXEL_BITS = 12,
    parameter int FRAC_BITS  = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire logic [PIXEL_BITS-1:0] i_pixel_x,
    input  wire logic [PIXEL_BITS-1:0] i_pixel_y,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output logic signed [31:0]         o_origin_x,
    output logic signed [31:0]         o_origin_y,
    output logic signed [31:0]         o_origin_z,
    output logic signed [31:0]         o_dir_x,
    output logic signed [31:0]         o_dir_y,
    output logic signed [31:0]         o_dir_z,
    output logic                       o_degenerate,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [5:0]            paddr,
    input  wire logic [63:0]           pwdata,
    output logic [63:0]                prdata,
    output logic                       pready
);

    logic [63:0] r_cfg [8];
    logic [2:0]  widx;
    logic        wr_en;

    // Register file: eight 64-bit registers at byte address 8*i.
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign widx   = paddr[5:3];
    assign prdata = r_cfg[widx];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg[0] <= 64'd65536;
            r_cfg[1] <= 64'd0;
            r_cfg[2] <= 64'd65536 << 32;
            r_cfg[3] <= 64'd0;
            r_cfg[4] <= 64'd0;
            r_cfg[5] <= 64'd65536;
            r_cfg[6] <= 64'd0;
            r_cfg[7] <= 64'd0;
        end else if (wr_en) begin
            if (widx == REG_PIXEL_SIZE) begin
                r_cfg[widx] <= {33'd0, pwdata[30:0]};
            end else begin
                r_cfg[widx] <= pwdata;
            end
        end
    end

    // Matrix view of the registers.
    t_mat3 mat;
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            mat[k][0] = r_cfg[2*k][31:0];
            mat[k][1] = r_cfg[2*k][63:32];
            mat[k][2] = r_cfg[2*k+1][31:0];
        end
    end

    // Front part.
    logic   f_valid;
    logic   q_not_full;
    t_plane f_plane;
    crg_front #(
        .PIXEL_BITS(PIXEL_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_pixel_x    (i_pixel_x),
        .i_pixel_y    (i_pixel_y),
        .i_half_w     (r_cfg[6][31:0]),
        .i_half_h     (r_cfg[6][63:32]),
        .i_pixel_size (r_cfg[REG_PIXEL_SIZE][30:0]),
        .o_valid      (f_valid),
        .i_ready      (q_not_full),
        .o_plane      (f_plane)
    );

    // Queue between the parts.
    logic   q_not_empty;
    logic   b_ready;
    t_plane q_plane;
    crg_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (f_valid),
        .o_not_full  (q_not_full),
        .i_data      (f_plane),
        .o_not_empty (q_not_empty),
        .i_pop       (b_ready),
        .o_data      (q_plane)
    );

    // Back part.
    logic [31:0] dx;
    logic [31:0] dy;
    logic [31:0] dz;
    crg_back #(
        .FRAC_BITS(FRAC_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (q_not_empty),
        .o_ready      (b_ready),
        .i_plane      (q_plane),
        .i_mat        (mat),
        .o_valid      (o_out_valid),
        .i_ready      (i_out_ready),
        .o_dir_x      (dx),
        .o_dir_y      (dy),
        .o_dir_z      (dz),
        .o_degenerate (o_degenerate)
    );

    assign o_dir_x    = $signed(dx);
    assign o_dir_y    = $signed(dy);
    assign o_dir_z    = $signed(dz);
    assign o_origin_x = $signed(r_cfg[1][63:32]);
    assign o_origin_y = $signed(r_cfg[3][63:32]);
    assign o_origin_z = $signed(r_cfg[5][63:32]);

    // A zero direction can only come from the degenerate case.
    a_zero_dir_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_dir_x == 0 && o_dir_y == 0 && o_dir_z == 0) |-> o_degenerate)
        else $error("zero direction without degenerate flag");

    // Directions stay within the unit range.
    a_dir_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_dir_x <= 32'sd1073741824 && o_dir_x >= -32'sd1073741824
                      && o_dir_y <= 32'sd1073741824 && o_dir_y >= -32'sd1073741824
                      && o_dir_z <= 32'sd1073741824 && o_dir_z >= -32'sd1073741824))
        else $error("direction out of range");

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

endmodule
`default_nettype wire

@@ hw/rtl/crg_front.sv @@
// Front part of the camera ray generator: takes pixel beats and forms the
// image plane point. Depends on crg_pkg.
`default_nettype none
module crg_front
    import crg_pkg::*;
#(
    parameter int PIXEL_BITS = 12
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire logic [PIXEL_BITS-1:0] i_pixel_x,
    input  wire logic [PIXEL_BITS-1:0] i_pixel_y,
    input  wire logic [31:0]           i_half_w,
    input  wire logic [31:0]           i_half_h,
    input  wire logic [30:0]           i_pixel_size,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output t_plane                     o_plane
);

    localparam int MW = 31 + PIXEL_BITS + 1;
    localparam int VW = MW + 2;
    localparam logic signed [VW-1:0] VMAX = (VW)'(64'sd2147483647);
    localparam logic signed [VW-1:0] VMIN = (VW)'(-64'sd2147483648);

    logic   r_valid;
    t_plane r_plane;
    t_plane n_plane;
    logic   sat_x;
    logic   sat_y;
    logic [31:0] pt_x;
    logic [31:0] pt_y;

    // Forms h - (p + 0.5) * s exactly, floors the half and saturates to 32 bits.
    function automatic logic [32:0] plane_f(
        input logic [31:0]           h,
        input logic [PIXEL_BITS-1:0] p,
        input logic [30:0]           s
    );
        logic [PIXEL_BITS:0] odd;
        logic [MW-1:0]       prod;
        logic signed [VW-1:0] v;
        logic [32:0]         res;
        odd  = {p, 1'b1};
        prod = odd * s;
        v = $signed({{(VW-33){1'b0}}, h, 1'b0}) - $signed({2'b00, prod});
        v = v >>> 1;
        if (v > VMAX) begin
            res = {1'b1, 32'h7fff_ffff};
        end else if (v < VMIN) begin
            res = {1'b1, 32'h8000_0000};
        end else begin
            res = {1'b0, v[31:0]};
        end
        return res;
    endfunction

    assign {sat_x, pt_x} = plane_f(i_half_w, i_pixel_x, i_pixel_size);
    assign {sat_y, pt_y} = plane_f(i_half_h, i_pixel_y, i_pixel_size);

    always_comb begin
        n_plane.px  = pt_x;
        n_plane.py  = pt_y;
        n_plane.deg = sat_x | sat_y;
    end

    // The stage takes a new beat whenever it is empty or its beat moves on.
    assign o_in_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_plane <= n_plane;
        end
    end

    assign o_valid = r_valid;
    assign o_plane = r_plane;

endmodule
`default_nettype wire

@@ hw/rtl/crg_queue.sv @@
// Short queue of plane points between the front and back parts.
// Depends on crg_pkg for the entry type and depth.
`default_nettype none
module crg_queue
    import crg_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    output logic      o_not_full,
    input  t_plane    i_data,
    output logic      o_not_empty,
    input  wire logic i_pop,
    output t_plane    o_data
);

    t_plane            r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QCNT_W-1:0] r_cnt;
    logic              do_push;
    logic              do_pop;

    assign o_not_full  = (r_cnt != QCNT_W'(QDEPTH));
    assign o_not_empty = (r_cnt != '0);
    assign do_push     = i_push && o_not_full;
    assign do_pop      = i_pop && o_not_empty;
    assign o_data      = r_mem[r_rd];

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule
`default_nettype wire

@@ hw/rtl/crg_back.sv @@
// Back part of the camera ray generator: matrix product, normalization,
// pipelined square root, reciprocal and final scaling. Depends on crg_pkg.
`default_nettype none
module crg_back
    import crg_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_ready,
    input  t_plane    i_plane,
    input  t_mat3     i_mat,
    output logic      o_valid,
    input  wire logic i_ready,
    output logic [31:0] o_dir_x,
    output logic [31:0] o_dir_y,
    output logic [31:0] o_dir_z,
    output logic      o_degenerate
);

    // Stage map: products, sums, magnitude, leading one, shift, squares, sum,
    // root steps, divide steps, partial products, output.
    localparam int PRE = 7;
    localparam int NST = PRE + SQRT_STEPS + RECIP_STEPS + 2;

    logic [NST-1:0] r_vld;
    logic           adv;

    // Whole pipeline advances unless the output beat is held.
    assign adv     = !r_vld[NST-1] || i_ready;
    assign o_ready = adv;
    assign o_valid = r_vld[NST-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[NST-2:0], i_valid};
        end
    end

    // Stage 0: the nine products, each floored by a quarter.
    logic signed [63:0] n_pr [3][3];
    logic signed [63:0] r_pr [3][3];
    logic               r_deg0;
    always_comb begin
        logic signed [63:0] t;
        for (int k = 0; k < 3; k++) begin
            n_pr[k][0] = ($signed(i_mat[k][0]) * $signed(i_plane.px)) >>> 2;
            n_pr[k][1] = ($signed(i_mat[k][1]) * $signed(i_plane.py)) >>> 2;
            t = $signed({{32{i_mat[k][2][31]}}, i_mat[k][2]}) <<< FRAC_BITS;
            n_pr[k][2] = (-t) >>> 2;
        end
    end
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_pr   <= n_pr;
            r_deg0 <= i_plane.deg;
        end
    end

    // Stage 1: row sums.
    logic signed [63:0] r_d1 [3];
    logic               r_deg1;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int k = 0; k < 3; k++) begin
                r_d1[k] <= r_pr[k][0] + r_pr[k][1] + r_pr[k][2];
            end
            r_deg1 <= r_deg0;
        end
    end

    // Stage 2: largest magnitude.
    logic signed [63:0] r_d2 [3];
    logic [63:0]        r_mag;
    logic               r_deg2;
    logic [63:0]        a0;
    logic [63:0]        a1;
    logic [63:0]        a2;
    logic [63:0]        a01;
    assign a0  = r_d1[0][63] ? 64'(-r_d1[0]) : 64'(r_d1[0]);
    assign a1  = r_d1[1][63] ? 64'(-r_d1[1]) : 64'(r_d1[1]);
    assign a2  = r_d1[2][63] ? 64'(-r_d1[2]) : 64'(r_d1[2]);
    assign a01 = (a1 > a0) ? a1 : a0;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_d2   <= r_d1;
            r_mag  <= (a2 > a01) ? a2 : a01;
            r_deg2 <= r_deg1;
        end
    end

    // Stage 3: position of the leading one.
    logic signed [63:0] r_d3 [3];
    logic [5:0]         r_pos;
    logic               r_zero3;
    logic               r_deg3;
    logic [5:0]         n_pos;
    always_comb begin
        n_pos = '0;
        for (int i = 0; i < 64; i++) begin
            if (r_mag[i]) begin
                n_pos = 6'(i);
            end
        end
    end
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_d3    <= r_d2;
            r_pos   <= n_pos;
            r_zero3 <= (r_mag == '0);
            r_deg3  <= r_deg2;
        end
    end

    // Stage 4: scale so the largest magnitude lies in [2^29, 2^30).
    logic [2:0][31:0]   r_c4;
    logic               r_zero4;
    logic               r_deg4;
    logic [2:0][31:0]   n_c4;
    always_comb begin
        logic [5:0] sh;
        logic signed [63:0] t;
        for (int k = 0; k < 3; k++) begin
            if (r_pos >= 6'(NORM_POS)) begin
                sh = r_pos - 6'(NORM_POS);
                t  = r_d3[k] >>> sh;
            end else begin
                sh = 6'(NORM_POS) - r_pos;
                t  = r_d3[k] <<< sh;
            end
            n_c4[k] = t[31:0];
        end
    end
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_c4    <= n_c4;
            r_zero4 <= r_zero3;
            r_deg4  <= r_deg3;
        end
    end

    // Stage 5: squares.
    logic [63:0]      r_sq [3];
    t_side            r_side5;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int k = 0; k < 3; k++) begin
                r_sq[k] <= $signed(r_c4[k]) * $signed(r_c4[k]);
            end
            r_side5.c    <= r_c4;
            r_side5.deg  <= r_deg4;
            r_side5.zero <= r_zero4;
        end
    end

    // Stage 6: sum of squares.
    logic [61:0] r_sum;
    t_side       r_side6;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_sum   <= 62'(r_sq[0] + r_sq[1] + r_sq[2]);
            r_side6 <= r_side5;
        end
    end

    // Square root, one result bit per stage by digit recurrence.
    logic [61:0] r_sq_num  [SQRT_STEPS];
    logic [32:0] r_sq_rem  [SQRT_STEPS];
    logic [30:0] r_sq_root [SQRT_STEPS];
    t_side       r_sq_side [SQRT_STEPS];

    for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_sqrt
        logic [61:0] num_in;
        logic [32:0] rem_in;
        logic [30:0] root_in;
        t_side       side_in;
        logic [34:0] w;
        logic [34:0] t;
        if (g == 0) begin : g_first
            assign num_in  = r_sum;
            assign rem_in  = '0;
            assign root_in = '0;
            assign side_in = r_side6;
        end else begin : g_next
            assign num_in  = r_sq_num[g-1];
            assign rem_in  = r_sq_rem[g-1];
            assign root_in = r_sq_root[g-1];
            assign side_in = r_sq_side[g-1];
        end
        assign w = {rem_in[32:0], num_in[61:60]};
        assign t = {2'b00, root_in, 2'b01};
        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_sq_num[g]  <= {num_in[59:0], 2'b00};
                r_sq_side[g] <= side_in;
                if (w >= t) begin
                    r_sq_rem[g]  <= 33'(w - t);
                    r_sq_root[g] <= {root_in[29:0], 1'b1};
                end else begin
                    r_sq_rem[g]  <= w[32:0];
                    r_sq_root[g] <= {root_in[29:0], 1'b0};
                end
            end
        end
    end

    // Reciprocal 2^62 / L by restoring division, one quotient bit per stage.
    logic [30:0]            r_dv_rem  [RECIP_STEPS];
    logic [RECIP_STEPS-1:0] r_dv_quo  [RECIP_STEPS];
    logic [30:0]            r_dv_len  [RECIP_STEPS];
    t_side                  r_dv_side [RECIP_STEPS];

    for (genvar g = 0; g < RECIP_STEPS; g++) begin : g_div
        logic [30:0]            rem_in;
        logic [RECIP_STEPS-1:0] quo_in;
        logic [30:0]            len_in;
        t_side                  side_in;
        logic [31:0]            w;
        if (g == 0) begin : g_first
            assign rem_in  = 31'(1) << (62 - RECIP_STEPS);
            assign quo_in  = '0;
            assign len_in  = r_sq_root[SQRT_STEPS-1];
            assign side_in = r_sq_side[SQRT_STEPS-1];
        end else begin : g_next
            assign rem_in  = r_dv_rem[g-1];
            assign quo_in  = r_dv_quo[g-1];
            assign len_in  = r_dv_len[g-1];
            assign side_in = r_dv_side[g-1];
        end
        assign w = {rem_in, 1'b0};
        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_dv_len[g]  <= len_in;
                r_dv_side[g] <= side_in;
                if (w >= {1'b0, len_in}) begin
                    r_dv_rem[g] <= 31'(w - {1'b0, len_in});
                    r_dv_quo[g] <= {quo_in[RECIP_STEPS-2:0], 1'b1};
                end else begin
                    r_dv_rem[g] <= w[30:0];
                    r_dv_quo[g] <= {quo_in[RECIP_STEPS-2:0], 1'b0};
                end
            end
        end
    end

    // Partial products of component times reciprocal.
    localparam int HW = RECIP_STEPS - RSPLIT;
    logic [RECIP_STEPS-1:0] recip;
    logic signed [32+HW:0]     r_ph [3];
    logic signed [32+RSPLIT:0] r_pl [3];
    t_side                     r_side_p;
    assign recip = r_dv_quo[RECIP_STEPS-1];
    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int k = 0; k < 3; k++) begin
                r_ph[k] <= $signed(r_dv_side[RECIP_STEPS-1].c[k])
                         * $signed({1'b0, recip[RECIP_STEPS-1:RSPLIT]});
                r_pl[k] <= $signed(r_dv_side[RECIP_STEPS-1].c[k])
                         * $signed({1'b0, recip[RSPLIT-1:0]});
            end
            r_side_p <= r_dv_side[RECIP_STEPS-1];
        end
    end

    // Output stage: combine, round, clamp; a zero vector gives zero.
    logic [2:0][31:0] n_dir;
    logic [2:0][31:0] r_dir;
    logic             r_deg_o;
    always_comb begin
        logic signed [67:0] v;
        logic signed [35:0] q;
        for (int k = 0; k < 3; k++) begin
            v = (68'(r_ph[k]) <<< RSPLIT) + 68'(r_pl[k]) + (68'sd1 <<< 31);
            q = 36'(v >>> 32);
            if (r_side_p.zero) begin
                n_dir[k] = '0;
            end else if (q > DIR_MAX) begin
                n_dir[k] = DIR_MAX[31:0];
            end else if (q < DIR_MIN) begin
                n_dir[k] = DIR_MIN[31:0];
            end else begin
                n_dir[k] = q[31:0];
            end
        end
    end
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_dir   <= n_dir;
            r_deg_o <= r_side_p.deg | r_side_p.zero;
        end
    end

    assign o_dir_x      = r_dir[0];
    assign o_dir_y      = r_dir[1];
    assign o_dir_z      = r_dir[2];
    assign o_degenerate = r_deg_o;

endmodule
`default_nettype wire

@@ dv/tb.sv @@
// Self-checking bench for camera_ray_generator_unit: pixel beats in, ray beats out.
// Depends on crg_pkg and the block's RTL; the expected rays come from a local model.
`default_nettype none
module tb;
    import crg_pkg::*;

    localparam int PBITS   = 12;
    localparam int FBITS   = 16;
    localparam int LIMIT   = 2000000;
    localparam int LATENCY = 76;

    localparam logic [2:0] REG_R0L = 3'd0;
    localparam logic [2:0] REG_R0R = 3'd1;
    localparam logic [2:0] REG_R1L = 3'd2;
    localparam logic [2:0] REG_R1R = 3'd3;
    localparam logic [2:0] REG_R2L = 3'd4;
    localparam logic [2:0] REG_R2R = 3'd5;
    localparam logic [2:0] REG_HEXT = 3'd6;

    typedef struct packed {
        logic [PBITS-1:0] x;
        logic [PBITS-1:0] y;
    } t_pixel;

    typedef struct packed {
        logic [31:0] ox;
        logic [31:0] oy;
        logic [31:0] oz;
        logic [31:0] dx;
        logic [31:0] dy;
        logic [31:0] dz;
        logic        deg;
    } t_ray;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic [PBITS-1:0] i_pixel_x = '0;
    logic [PBITS-1:0] i_pixel_y = '0;
    logic i_out_ready = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [5:0] paddr = '0;
    logic [63:0] pwdata = '0;
    wire o_in_ready, o_out_valid, o_degenerate, pready;
    wire signed [31:0] o_origin_x, o_origin_y, o_origin_z, o_dir_x, o_dir_y, o_dir_z;
    wire [63:0] prdata;

    camera_ray_generator_unit #(.PIXEL_BITS(PBITS), .FRAC_BITS(FBITS)) u_dut (
        .i_clk, .i_rst_n, .i_in_valid, .o_in_ready, .i_pixel_x, .i_pixel_y,
        .o_out_valid, .i_out_ready, .o_origin_x, .o_origin_y, .o_origin_z,
        .o_dir_x, .o_dir_y, .o_dir_z, .o_degenerate,
        .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
    );

    // Shadow copy of the configuration registers.
    logic [63:0] cam_regs [8];

    t_pixel pixel_queue[$];
    t_ray   ray_queue[$];
    int  errors = 0;
    int  cycles = 0;
    int  rays_seen = 0;
    int  send_idle = 0;
    int  recv_stall = 0;
    int  hold_off = 0;
    logic in_taken = 1'b0;

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Timeout guard.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic longint floor_shr(longint v, int k);
        return v >>> k;
    endfunction

    function automatic longint sext32(logic [31:0] v);
        return longint'(signed'(v));
    endfunction

    function automatic longint mat_at(int row, int col);
        logic [63:0] r;
        r = cam_regs[row * 2 + col / 2];
        return sext32((col % 2) ? r[63:32] : r[31:0]);
    endfunction

    function automatic longint plane_coord(longint h, longint p, longint s, inout bit sat);
        longint v;
        v = floor_shr(2 * h - (2 * p + 1) * s, 1);
        if (v > 64'sd2147483647) begin
            sat = 1'b1;
            v = 64'sd2147483647;
        end else if (v < -64'sd2147483648) begin
            sat = 1'b1;
            v = -64'sd2147483648;
        end
        return v;
    endfunction

    function automatic logic [63:0] int_sqrt(logic [63:0] n);
        logic [63:0] res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv >>= 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n = n - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    // Computes the ray expected for one pixel.
    function automatic t_ray trace_pixel(t_pixel px);
        t_ray r;
        bit deg;
        longint p[3], d[3], c[3], m, t, a, v, s;
        logic [63:0] sum, len, recip;
        int rs, ls;
        deg = 1'b0;
        s = longint'(cam_regs[7][30:0]);
        p[0] = plane_coord(longint'(cam_regs[6][31:0]), longint'(px.x), s, deg);
        p[1] = plane_coord(longint'(cam_regs[6][63:32]), longint'(px.y), s, deg);
        p[2] = -(64'sd1 << FBITS);
        m = 0;
        for (int i = 0; i < 3; i++) begin
            d[i] = 0;
            for (int j = 0; j < 3; j++) d[i] += floor_shr(mat_at(i, j) * p[j], 2);
            a = d[i] < 0 ? -d[i] : d[i];
            if (a > m) m = a;
        end
        r.ox = 32'(mat_at(0, 3));
        r.oy = 32'(mat_at(1, 3));
        r.oz = 32'(mat_at(2, 3));
        if (m == 0) begin
            r.dx = '0;
            r.dy = '0;
            r.dz = '0;
            r.deg = 1'b1;
            return r;
        end
        rs = 0;
        ls = 0;
        t = m;
        while (t >= (64'sd1 << 30)) begin
            t >>>= 1;
            rs++;
        end
        while (t < (64'sd1 << 29)) begin
            t <<= 1;
            ls++;
        end
        sum = 0;
        for (int i = 0; i < 3; i++) begin
            c[i] = rs ? floor_shr(d[i], rs) : d[i] <<< ls;
            sum += c[i] * c[i];
        end
        len = int_sqrt(sum);
        recip = (64'd1 << 62) / len;
        for (int i = 0; i < 3; i++) begin
            v = floor_shr(c[i] * longint'(recip) + (64'sd1 << 31), 32);
            if (v > (64'sd1 << 30)) v = 64'sd1 << 30;
            if (v < -(64'sd1 << 30)) v = -(64'sd1 << 30);
            if (i == 0) r.dx = v[31:0];
            else if (i == 1) r.dy = v[31:0];
            else r.dz = v[31:0];
        end
        r.deg = deg;
        return r;
    endfunction

    // Remembers whether the last rising edge took a pixel beat.
    always @(posedge i_clk) begin
        in_taken <= i_rst_n && i_in_valid && o_in_ready;
    end

    // Driver: presents queued pixels; a new beat can follow an accepted one directly, unless a random idle is drawn.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_taken) begin
            if (in_taken) void'(pixel_queue.pop_front());
            if ((pixel_queue.size() > 0) && ($urandom_range(99) >= send_idle)) begin
                i_in_valid <= 1'b1;
                i_pixel_x <= pixel_queue[0].x;
                i_pixel_y <= pixel_queue[0].y;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Predicts the ray when the block takes a pixel beat.
    always @(posedge i_clk) begin
        t_pixel px;
        if (i_rst_n && i_in_valid && o_in_ready) begin
            px.x = i_pixel_x;
            px.y = i_pixel_y;
            ray_queue.push_back(trace_pixel(px));
        end
    end

    // Receiver ready, with random stalls and one long hold-off.
    always @(negedge i_clk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_stall);
        end
    end

    // Monitor: compares each ray beat with the oldest prediction.
    always @(posedge i_clk) begin
        t_ray want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            rays_seen <= rays_seen + 1;
            if (ray_queue.size() == 0) begin
                $error("ray beat with no pixel pending");
                errors++;
            end else begin
                want = ray_queue.pop_front();
                if (o_origin_x !== want.ox) begin
                    $error("origin_x expected %h got %h", want.ox, o_origin_x);
                    errors++;
                end
                if (o_origin_y !== want.oy) begin
                    $error("origin_y expected %h got %h", want.oy, o_origin_y);
                    errors++;
                end
                if (o_origin_z !== want.oz) begin
                    $error("origin_z expected %h got %h", want.oz, o_origin_z);
                    errors++;
                end
                if (o_dir_x !== want.dx) begin
                    $error("dir_x expected %h got %h", want.dx, o_dir_x);
                    errors++;
                end
                if (o_dir_y !== want.dy) begin
                    $error("dir_y expected %h got %h", want.dy, o_dir_y);
                    errors++;
                end
                if (o_dir_z !== want.dz) begin
                    $error("dir_z expected %h got %h", want.dz, o_dir_z);
                    errors++;
                end
                if (o_degenerate !== want.deg) begin
                    $error("degenerate expected %b got %b", want.deg, o_degenerate);
                    errors++;
                end
            end
        end
    end

    // APB write with setup and access phases; the shadow copy follows the block's masking.
    task automatic write_reg(logic [2:0] idx, logic [63:0] val);
        @(negedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= {idx, 3'b000};
        pwdata <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        cam_regs[idx] = (idx == REG_PIXEL_SIZE) ? {33'd0, val[30:0]} : val;
    endtask

    // Waits until every predicted ray has arrived, then lets the pipe drain.
    task automatic wait_drained();
        while (pixel_queue.size() != 0 || ray_queue.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 8) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_entry(int mode);
        case (mode)
            0: return 32'h0001_0000;
            1: return 32'hFFFF_0000;
            2: return 32'h7FFF_FFFF;
            3: return 32'h8000_0000;
            4: return 32'd0;
            default: return $urandom_range(32'h0004_0000) - 32'h0002_0000;
        endcase
    endfunction

    // Loads one camera setting: matrix entries, extents and pixel size.
    task automatic load_camera(int mode);
        logic [31:0] hw, hh, s;
        for (int r = 0; r < 3; r++) begin
            write_reg(3'(2 * r), {rand_entry(mode > 5 ? $urandom_range(7) : 5),
                rand_entry(mode == 1 ? 2 : 5)});
            write_reg(3'(2 * r + 1), {(mode == 2) ? rand_entry(3) : $urandom(),
                rand_entry(mode == 3 ? 3 : 5)});
        end
        hw = (mode == 2) ? 32'hFFFF_FFFF : $urandom_range(32'h0100_0000);
        hh = (mode == 2) ? 32'hFFFF_FFFF : $urandom_range(32'h0100_0000);
        s = (mode == 2) ? 32'h7FFF_FFFF : (mode == 3) ? 32'd0 : $urandom_range(32'h0000_2000);
        write_reg(REG_HEXT, {hh, hw});
        write_reg(REG_PIXEL_SIZE, {$urandom(), s});
    endtask

    task automatic queue_random(int n);
        t_pixel px;
        for (int i = 0; i < n; i++) begin
            px.x = $urandom();
            px.y = $urandom();
            pixel_queue.push_back(px);
        end
    endtask

    initial begin
        t_pixel px;
        for (int i = 0; i < 8; i++) cam_regs[i] = 0;
        cam_regs[REG_R0L] = 64'd65536;
        cam_regs[REG_R1L] = 64'd65536 << 32;
        cam_regs[REG_R2R] = 64'd65536;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset identity setting with zero pixel size: pixel extremes.
        px = '{x: 0, y: 0};
        pixel_queue.push_back(px);
        px = '{x: '1, y: '1};
        pixel_queue.push_back(px);
        wait_drained();

        // Directed: saturating plane point, zero matrix, extreme entries, zero pixel size.
        load_camera(2);
        px = '{x: 0, y: '1};
        pixel_queue.push_back(px);
        px = '{x: '1, y: 0};
        pixel_queue.push_back(px);
        px = '{x: 12'h555, y: 12'hAAA};
        pixel_queue.push_back(px);
        wait_drained();
        for (int r = 0; r < 6; r++) write_reg(3'(r), 64'd0);
        px = '{x: 7, y: 9};
        pixel_queue.push_back(px);
        px = '{x: '1, y: '1};
        pixel_queue.push_back(px);
        wait_drained();
        load_camera(1);
        queue_random(6);
        wait_drained();
        load_camera(3);
        queue_random(6);
        wait_drained();

        // Random phases across idling patterns and settings.
        for (int ph = 0; ph < 8; ph++) begin
            load_camera(ph % 4 == 2 ? 2 : 5 + ph % 3);
            send_idle = (ph % 4 == 1 || ph % 4 == 3) ? (ph % 4 == 1 ? 73 : 23) : 0;
            recv_stall = (ph % 4 == 2 || ph % 4 == 3) ? (ph % 4 == 2 ? 73 : 23) : 0;
            if (ph == 4) send_idle = 0;
            if (ph == 0) hold_off = 300;
            queue_random(200);
            wait_drained();
        end
        send_idle = 0;
        recv_stall = 0;
        load_camera(0);
        queue_random(30);
        wait_drained();

        $display("Covered %0d rays over identity, zero, saturating and random cameras,",
            rays_seen);
        $display("with idle and stalled phases and a long receiver hold-off.");
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
`default_nettype wire
